### hdl/dfa_string_recognizer_assert.svh
// ----------------------------------------------------------------------------
// DFA recogniser assertion macros
// Shared shorthand for the concurrent checks of the recogniser.
// ----------------------------------------------------------------------------
`ifndef DFA_STRING_RECOGNIZER_ASSERT_SVH
`define DFA_STRING_RECOGNIZER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define DSR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// DFA recogniser package
// Widths, command codes and shared types of the recogniser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

    localparam int STATE_BITS    = 4;
    localparam int SYMBOL_BITS   = 8;
    localparam int ADDR_BITS     = STATE_BITS + SYMBOL_BITS;
    localparam int ENTRY_BITS    = 1 + STATE_BITS;
    localparam int MASK_BITS     = 16;
    localparam int CMD_BITS      = 2;
    localparam int IN_FIELD_BITS = SYMBOL_BITS + 2 * STATE_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SYMBOL = 2'd0,
        CMD_END    = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                   cmd;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [STATE_BITS-1:0]  from_state;
        logic [STATE_BITS-1:0]  to_state;
    } t_item;

    typedef struct packed {
        logic clearing;
        logic lookup;
    } t_back_status;

    // states without a mask bit are never accepting
    function automatic logic is_final(input logic [MASK_BITS-1:0] mask,
                                      input logic [STATE_BITS-1:0] st);
        logic [STATE_BITS+3:0] ext;
        ext = {4'd0, st};
        if (ext < (STATE_BITS + 4)'(MASK_BITS)) begin
            return mask[ext[3:0]];
        end
        return 1'b0;
    endfunction

endpackage

`default_nettype wire

### hdl/dsr_front.sv
// ----------------------------------------------------------------------------
// DFA recogniser front end
// Takes input transactions, unpacks and classifies them, drops unused
// commands and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_front (
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tuser: cmd
    input  wire logic [dsr_pkg::CMD_BITS-1:0]       i_s_tuser,
    // tdata: symbol, from_state, to_state, zero pad
    input  wire logic [dsr_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input  wire dsr_pkg::t_back_status              i_status,
    input  wire logic                               i_q_full,
    output logic                                    o_push,
    output dsr_pkg::t_item                          o_item
);

    localparam int FROM_LSB = dsr_pkg::SYMBOL_BITS;
    localparam int TO_LSB   = dsr_pkg::SYMBOL_BITS + dsr_pkg::STATE_BITS;

    always_comb begin
        o_s_tready        = !i_q_full && !i_status.clearing;
        o_item.cmd        = dsr_pkg::t_cmd'(i_s_tuser);
        o_item.symbol     = i_s_tdata[dsr_pkg::SYMBOL_BITS-1:0];
        o_item.from_state = i_s_tdata[FROM_LSB +: dsr_pkg::STATE_BITS];
        o_item.to_state   = i_s_tdata[TO_LSB +: dsr_pkg::STATE_BITS];
        // unused command has no effect at all, so it never reaches the queue
        o_push            = i_s_tvalid && o_s_tready && (o_item.cmd != dsr_pkg::CMD_UNUSED);
    end

endmodule

`default_nettype wire

### hdl/dsr_queue.sv
// ----------------------------------------------------------------------------
// DFA recogniser command queue
// Two-entry FIFO between the front end and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dsr_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output dsr_pkg::t_item      o_head
);

    dsr_pkg::t_item r_slot [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_count, n_count;

    always_comb begin
        o_full  = (r_count == 2'd2);
        o_valid = (r_count != 2'd0);
        o_head  = r_slot[r_rptr];
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### hdl/dsr_back.sv
// ----------------------------------------------------------------------------
// DFA recogniser executor
// Holds the transition table, walks it for symbols, stores written
// transitions and presents end-of-word verdicts in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dsr_pkg::MASK_BITS-1:0]       i_cfg_wdata,
    input  wire logic                                i_q_valid,
    input  wire dsr_pkg::t_item                      i_q_head,
    output logic                                     o_pop,
    output dsr_pkg::t_back_status                    o_status,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: accepted, fell_off, zero pad
    output logic [dsr_pkg::OUT_DATA_BITS-1:0]        o_m_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_RUN    = 3'b010,
        S_LOOKUP = 3'b100
    } t_back_state;

    localparam int AW = dsr_pkg::ADDR_BITS;
    localparam int SB = dsr_pkg::STATE_BITS;
    localparam int EW = dsr_pkg::ENTRY_BITS;

    // entry: present bit above next state
    logic [EW-1:0] mem [2**AW];

    t_back_state                    r_state, n_state;
    logic [AW-1:0]                  r_clr_addr, n_clr_addr;
    logic [SB-1:0]                  r_cur, n_cur;
    logic                           r_dead, n_dead;
    logic [dsr_pkg::MASK_BITS-1:0]  r_mask;
    logic                           r_out_valid, n_out_valid;
    logic [1:0]                     r_out_data, n_out_data;
    logic [EW-1:0]                  r_rd_data;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          can_emit;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur       = r_cur;
        n_dead      = r_dead;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_addr     = {i_q_head.from_state, i_q_head.symbol};
        wr_data     = {1'b1, i_q_head.to_state};
        rd_en       = 1'b0;
        rd_addr     = {r_cur, i_q_head.symbol};
        o_pop       = 1'b0;
        can_emit    = !r_out_valid || i_m_tready;

        unique case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_q_valid) begin
                    unique case (i_q_head.cmd)
                        dsr_pkg::CMD_SYMBOL: begin
                            o_pop = 1'b1;
                            if (!r_dead) begin
                                rd_en   = 1'b1;
                                n_state = S_LOOKUP;
                            end
                        end
                        dsr_pkg::CMD_END: begin
                            if (can_emit) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = {r_dead,
                                               !r_dead && dsr_pkg::is_final(r_mask, r_cur)};
                                n_cur       = '0;
                                n_dead      = 1'b0;
                            end
                        end
                        dsr_pkg::CMD_WRITE: begin
                            o_pop = 1'b1;
                            wr_en = 1'b1;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                if (r_rd_data[EW-1]) begin
                    n_cur = r_rd_data[SB-1:0];
                end else begin
                    n_dead = 1'b1;
                end
                n_state = S_RUN;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        o_status.clearing = (r_state == S_CLEAR);
        o_status.lookup   = (r_state == S_LOOKUP);
        o_m_tvalid        = r_out_valid;
        o_m_tdata         = {{(dsr_pkg::OUT_DATA_BITS - 2){1'b0}}, r_out_data};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cur       <= '0;
            r_dead      <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cur       <= n_cur;
            r_dead      <= n_dead;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // transition table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/dfa_string_recognizer.sv
// ----------------------------------------------------------------------------
// DFA string recogniser
// Table-driven deterministic automaton with a streaming command interface.
// ----------------------------------------------------------------------------
// After reset the block sweeps its transition table, one entry a cycle, over all
// 2**(STATE_BITS+SYMBOL_BITS) = 4096 entries with s_tready low; the final-state
// mask may be written during that time. Each input transaction carries a
// command in tuser: a symbol is looked up in the table from the current state,
// an end of word returns one result (accepted, fell_off) and restarts at state
// 0, a write stores a transition. A symbol is handled by the executor as a
// synchronous table read and then a state update in the lookup state, as the next
// address depends on the read; writes, ends of word and symbols after a missing
// transition skip the lookup state. A two-entry queue and the output register
// decouple both sides, so input is taken while a result waits on the output.
`default_nettype none

`include "dfa_string_recognizer_assert.svh"

module dfa_string_recognizer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dsr_pkg::MASK_BITS-1:0]      i_cfg_wdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tuser: cmd
    input  wire logic [dsr_pkg::CMD_BITS-1:0]       i_s_tuser,
    // tdata: symbol, from_state, to_state, zero pad
    input  wire logic [dsr_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: accepted, fell_off, zero pad
    output logic [dsr_pkg::OUT_DATA_BITS-1:0]       o_m_tdata
);

    dsr_pkg::t_item        push_item;
    dsr_pkg::t_item        q_head;
    dsr_pkg::t_back_status status;
    logic                  q_push;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;

    dsr_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_status   (status),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_item     (push_item)
    );

    dsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    dsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    `DSR_ASSERT_IMPL(a_no_input_while_clearing, status.clearing, !o_s_tready,
        "input taken during table clear")
    `DSR_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full,
        "push into full queue")
    `DSR_ASSERT_NEXT(a_lookup_one_cycle, status.lookup, !status.lookup,
        "lookup lasted more than one cycle")
    `DSR_ASSERT_IMPL(a_dead_word_rejected, o_m_tvalid && o_m_tdata[1], !o_m_tdata[0],
        "word with missing transition reported as accepted")

endmodule

`default_nettype wire
